// File: hdl/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Shared sizes, derived widths and the sequencer state type.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Storage and field sizes.
  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  // Derived widths: slot index, and a count that can hold ENTRIES itself.
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_FETCH,
    ST_UPDATE,
    ST_DONE
  } lkv_state_e;

endpackage

`default_nettype wire

// File: hdl/lkv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted request is scanned, then goes through read and fetch when it hits or
//   evicts, then through update and done; the result is then handed to the output register.
// Requests: a new request is accepted only in idle, after the last result has left done;
//   the scan reads the key RAM one slot per cycle through its single read port.
// Reset: valid marks, entry count and output valid clear at once; capacity is 16.
// ----------------------------------------------------------------------------
// LRU key/value cache top level
// Fully associative key/value cache with least-recently-used replacement,
// run by a small sequencer that scans the key store one slot per cycle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
  import lkv_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CAP_W-1:0] cfg_data_i,
  // Request channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire logic [KEY_W-1:0] item_key_i,
  input  wire logic [VAL_W-1:0] item_value_i,
  // Result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  hit_o,
  output logic      [VAL_W-1:0] value_out_o,
  output logic                  evicted_o,
  output logic      [KEY_W-1:0] evicted_key_o,
  output logic      [VAL_W-1:0] evicted_value_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  lkv_state_e state_q, state_d;

  // Cache state
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   rank_q [ENTRIES];
  logic [IDX_W-1:0]   rank_d [ENTRIES];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAP_W-1:0]   cap_q;

  // Latched request
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Scan control and trackers
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             chk_q, chk_d;
  logic [IDX_W-1:0] chk_idx_q;
  logic             hit_found_q, hit_found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0] hit_rank_q, hit_rank_d;
  logic             vic_found_q, vic_found_d;
  logic [IDX_W-1:0] vic_idx_q, vic_idx_d;
  logic [IDX_W-1:0] vic_rank_q, vic_rank_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             evict_q, evict_d;
  logic             scan_last;
  logic             need_evict;
  logic [CMP_W-1:0] eff_cap;

  // Pending result and output register
  logic             res_ev_q;
  logic [VAL_W-1:0] res_val_q;
  logic [KEY_W-1:0] res_evk_q;
  logic [VAL_W-1:0] res_evv_q;
  logic             out_valid_q;
  logic             out_free;

  // RAM ports and update controls
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] key_rdata;
  logic [VAL_W-1:0] val_rdata;
  logic             ins_we;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;
  logic             accept;

  // Key and value stores.
  lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (slot_idx),
    .wdata_i (key_q),
    .raddr_i (ram_raddr),
    .rdata_o (key_rdata)
  );

  lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ins_we),
    .waddr_i (slot_idx),
    .wdata_i (val_q),
    .raddr_i (ram_raddr),
    .rdata_o (val_rdata)
  );

  // Effective capacity: zero acts as one, values above the store size clamp.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  assign need_evict = CMP_W'(count_q) >= eff_cap;
  assign scan_last  = chk_q && (chk_idx_q == LAST_IDX);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Scan trackers: first matching key, least recent valid entry, first free slot.
  always_comb begin
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_rank_d   = hit_rank_q;
    vic_found_d  = vic_found_q;
    vic_idx_d    = vic_idx_q;
    vic_rank_d   = vic_rank_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    if (state_q == ST_IDLE) begin
      hit_found_d  = 1'b0;
      vic_found_d  = 1'b0;
      free_found_d = 1'b0;
    end else if (state_q == ST_SCAN && chk_q) begin
      if (valid_q[chk_idx_q]) begin
        if (!hit_found_q && key_rdata == key_q) begin
          hit_found_d = 1'b1;
          hit_idx_d   = chk_idx_q;
          hit_rank_d  = rank_q[chk_idx_q];
        end
        if (!vic_found_q || rank_q[chk_idx_q] > vic_rank_q) begin
          vic_found_d = 1'b1;
          vic_idx_d   = chk_idx_q;
          vic_rank_d  = rank_q[chk_idx_q];
        end
      end else if (!free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = chk_idx_q;
      end
    end
  end

  // Eviction decision, settled when the last slot has been checked.
  always_comb begin
    evict_d = evict_q;
    if (state_q == ST_IDLE) begin
      evict_d = 1'b0;
    end else if (state_q == ST_SCAN && scan_last) begin
      evict_d = op_q && !hit_found_d && need_evict && vic_found_d;
    end
  end

  // Slot for a new key: the victim frees its slot before the new key lands.
  always_comb begin
    slot_ok  = free_found_q || evict_q;
    slot_idx = free_idx_q;
    if (evict_q && (!free_found_q || vic_idx_q < free_idx_q)) begin
      slot_idx = vic_idx_q;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = (hit_found_d || evict_d) ? ST_READ : ST_UPDATE;
        end
      end
      ST_READ:   state_d = ST_FETCH;
      ST_FETCH:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Output and control decode.
  always_comb begin
    in_stall_o = 1'b1;
    ram_raddr  = ptr_q[IDX_W-1:0];
    ins_we     = 1'b0;
    chk_d      = 1'b0;
    ptr_d      = ptr_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ptr_d      = '0;
      end
      ST_SCAN: begin
        chk_d = ptr_q < CNT_W'(ENTRIES);
        if (ptr_q < CNT_W'(ENTRIES)) begin
          ptr_d = ptr_q + CNT_W'(1);
        end
      end
      ST_READ: begin
        ram_raddr = hit_found_q ? hit_idx_q : vic_idx_q;
      end
      ST_FETCH: begin
      end
      ST_UPDATE: begin
        ins_we = op_q && !hit_found_q && slot_ok;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Recency, valid and count update for a hit or a new key.
  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    if (state_q == ST_UPDATE) begin
      if (hit_found_q) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && rank_q[i] < hit_rank_q) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
        rank_d[hit_idx_q] = '0;
      end else if (ins_we) begin
        if (evict_q) begin
          valid_d[vic_idx_q] = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_d[i]) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
        valid_d[slot_idx] = 1'b1;
        rank_d[slot_idx]  = '0;
        if (!evict_q) begin
          count_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      count_q      <= '0;
      cap_q        <= CAP_RESET;
      ptr_q        <= '0;
      chk_q        <= 1'b0;
      hit_found_q  <= 1'b0;
      vic_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      evict_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      chk_q        <= chk_d;
      hit_found_q  <= hit_found_d;
      vic_found_q  <= vic_found_d;
      free_found_q <= free_found_d;
      evict_q      <= evict_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rank_q     <= rank_d;
    chk_idx_q  <= ptr_q[IDX_W-1:0];
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    vic_idx_q  <= vic_idx_d;
    vic_rank_q <= vic_rank_d;
    free_idx_q <= free_idx_d;
    if (accept) begin
      op_q      <= op_i;
      key_q     <= item_key_i;
      val_q     <= item_value_i;
      res_ev_q  <= 1'b0;
      res_val_q <= '0;
      res_evk_q <= '0;
      res_evv_q <= '0;
    end
    if (state_q == ST_FETCH) begin
      if (hit_found_q) begin
        res_val_q <= val_rdata;
      end else begin
        res_ev_q  <= 1'b1;
        res_evk_q <= key_rdata;
        res_evv_q <= val_rdata;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      hit_o           <= hit_found_q;
      value_out_o     <= res_val_q;
      evicted_o       <= res_ev_q;
      evicted_key_o   <= res_evk_q;
      evicted_value_o <= res_evv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  // The entry count always equals the number of valid marks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count does not match valid marks");

  // The count never exceeds the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count above store size");

  // An insert of a new key always finds a slot to land in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && op_q && !hit_found_q) |-> slot_ok)
    else $error("insert found no slot");

  // A new key is valid and most recent right after its update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_we |=> (valid_q[$past(slot_idx)] && rank_q[$past(slot_idx)] == '0))
    else $error("inserted entry not valid and most recent");

  // A result never reports both a hit and an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction reported together");

endmodule

`default_nettype wire

// File: dv/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Drives lookup and insert requests into the cache, predicts every result
// with a behavioral copy of the LRU store, and compares each returned
// result field by field. Covers directed corner cases, capacity settings
// from zero to beyond the storage size, and random traffic under varying
// sender and receiver idling.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;
  import lkv_pkg::*;

  // Request operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam int POOL_MAX = 40;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             evicted;
    logic [KEY_W-1:0] ev_key;
    logic [VAL_W-1:0] ev_value;
  } cache_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             op_i = OP_LOOKUP;
  logic [KEY_W-1:0] item_key_i = '0;
  logic [VAL_W-1:0] item_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             hit_o;
  logic [VAL_W-1:0] value_out_o;
  logic             evicted_o;
  logic [KEY_W-1:0] evicted_key_o;
  logic [VAL_W-1:0] evicted_value_o;

  // Behavioral copy of the cache contents.
  bit               lru_valid[ENTRIES];
  logic [KEY_W-1:0] lru_key[ENTRIES];
  logic [VAL_W-1:0] lru_value[ENTRIES];
  int unsigned      lru_rank[ENTRIES];
  int unsigned      lru_count;
  logic [CAP_W-1:0] lru_capacity;

  cache_result_t    pending_results[$];
  int               failures = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  logic [KEY_W-1:0] key_pool[POOL_MAX];
  int               pool_size = 1;

  lru_key_value_cache_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .item_key_i     (item_key_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .value_out_o    (value_out_o),
    .evicted_o      (evicted_o),
    .evicted_key_o  (evicted_key_o),
    .evicted_value_o(evicted_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Computes the result of one request and updates the LRU copy.
  function automatic cache_result_t predict_cache(logic op, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] val);
    cache_result_t res;
    int            slot;
    int            victim;
    int            free_slot;
    int unsigned   limit;
    int unsigned   old_rank;
    res = '0;
    slot = -1;
    victim = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (lru_valid[i] && lru_key[i] == key && slot < 0) slot = i;
    end
    if (slot >= 0) begin
      // A hit returns the stored value and becomes the most recent entry.
      res.hit = 1'b1;
      res.value = lru_value[slot];
      old_rank = lru_rank[slot];
      for (int i = 0; i < ENTRIES; i++) begin
        if (lru_valid[i] && lru_rank[i] < old_rank) lru_rank[i]++;
      end
      lru_rank[slot] = 0;
    end else if (op == OP_INSERT) begin
      // Zero capacity acts as one, oversized capacity as the storage size.
      limit = (lru_capacity == 0) ? 1 :
              (lru_capacity > ENTRIES) ? ENTRIES : lru_capacity;
      if (lru_count + 1 > limit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (lru_valid[i] && (victim < 0 || lru_rank[i] > lru_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          res.evicted = 1'b1;
          res.ev_key = lru_key[victim];
          res.ev_value = lru_value[victim];
          lru_valid[victim] = 1'b0;
          lru_count--;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (!lru_valid[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (lru_valid[i]) lru_rank[i]++;
        end
        lru_valid[free_slot] = 1'b1;
        lru_key[free_slot] = key;
        lru_value[free_slot] = val;
        lru_rank[free_slot] = 0;
        lru_count++;
      end
    end
    return res;
  endfunction

  // Sends one request, with random idle cycles ahead of it.
  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    item_key_i <= key;
    item_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_cache(op, key, val));
  endtask

  // Holds off new requests until every expected result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);
  endtask

  // Writes the capacity register; the cache must be idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lru_capacity = cap;
    @(posedge clk_i);
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      failures++;
    end
  endtask

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result returned with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        report_field("hit", 32'(want.hit), 32'(hit_o));
        report_field("value_out", want.value, value_out_o);
        report_field("evicted", 32'(want.evicted), 32'(evicted_o));
        report_field("evicted_key", want.ev_key, evicted_key_o);
        report_field("evicted_value", want.ev_value, evicted_value_o);
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // Misses on an empty cache, extreme keys and values, and re-insert of a present key.
  task automatic test_lookup_insert();
    send_request(OP_LOOKUP, '0, $urandom());
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_LOOKUP, '1, $urandom());
    send_request(OP_LOOKUP, '0, $urandom());
    send_request(OP_INSERT, '0, 32'h1234_5678);
    send_request(OP_LOOKUP, 32'h5A5A_5A5A, $urandom());
  endtask

  // Fill every slot, then insert one more so the least recent entry goes.
  task automatic test_full_storage();
    for (int i = 1; i <= ENTRIES - 2; i++) begin
      send_request(OP_INSERT, KEY_W'(i * 32'h0101_0101), $urandom());
    end
    send_request(OP_INSERT, 32'hA5A5_0000, $urandom());
    send_request(OP_LOOKUP, 32'hA5A5_0000, $urandom());
  endtask

  // Capacity below the count, zero capacity and capacity above the storage size.
  task automatic test_capacity_limits();
    write_capacity(CAP_W'(3));
    send_request(OP_INSERT, 32'hC0DE_0001, $urandom());
    send_request(OP_INSERT, 32'hC0DE_0002, $urandom());
    write_capacity(CAP_W'(0));
    send_request(OP_INSERT, 32'hC0DE_0003, $urandom());
    send_request(OP_LOOKUP, 32'hC0DE_0003, $urandom());
    write_capacity(CAP_W'(31));
    send_request(OP_INSERT, 32'hC0DE_0004, $urandom());
    send_request(OP_LOOKUP, 32'hC0DE_0003, $urandom());
  endtask

  // Random traffic in segments, each with its own capacity and key pool.
  task automatic test_random_traffic(int segments, int per_segment, int tx_pct, int rx_pct);
    logic [CAP_W-1:0] cap;
    logic             op;
    logic [KEY_W-1:0] key;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(7))
        0: cap = CAP_W'(0);
        1: cap = CAP_W'(1);
        2: cap = CAP_W'(ENTRIES);
        3: cap = CAP_W'($urandom_range(ENTRIES + 1, 31));
        default: cap = CAP_W'($urandom_range(2, ENTRIES - 1));
      endcase
      write_capacity(cap);
      pool_size = $urandom_range(4, POOL_MAX);
      for (int p = 0; p < POOL_MAX; p++) key_pool[p] = $urandom();
      for (int n = 0; n < per_segment; n++) begin
        op = ($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP;
        key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(pool_size - 1)] : $urandom();
        send_request(op, key, $urandom());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_valid[i] = 1'b0;
      lru_key[i] = '0;
      lru_value[i] = '0;
      lru_rank[i] = 0;
    end
    lru_count = 0;
    lru_capacity = CAP_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_lookup_insert();
    test_full_storage();
    test_capacity_limits();
    test_random_traffic(10, 65, 21, 58);
    test_random_traffic(10, 65, 58, 21);
    test_random_traffic(10, 65, 0, 0);

    wait_for_results();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Safety limit for a hung handshake.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
